@@ src/mpwb_pkg.sv @@
package mpwb_pkg;

	// Sizes of the window store and of the image
	localparam int NUM_WINDOWS    = 8;
	localparam int NUM_CHANNELS   = 32;
	localparam int MAX_IMAGE_SIDE = 1024;

	localparam int WIN_W     = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TBL_DEPTH = NUM_WINDOWS * NUM_CHANNELS;
	localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int NW_W      = $clog2(NUM_WINDOWS + 1);
	localparam int SIDE_W    = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;

	// Field and datapath widths
	localparam int SMP_W   = 16;
	localparam int COEF_W  = 2 * SMP_W;
	localparam int PROD_W  = 2 * SMP_W + 1;
	localparam int ACC_W   = 40;
	localparam int HALF_W  = ACC_W / 2;
	localparam int POW_W   = 2 * ACC_W;
	localparam int IN_WIN_W = 3;
	localparam int IN_CH_W  = 5;
	localparam int OUT_WIN_W = 3;

	// Configuration registers
	localparam int CFG_NW_W   = 4;
	localparam int CFG_SIDE_W = 11;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam logic [1:0] REG_ACTIVE_WINDOWS = 2'd0;
	localparam logic [1:0] REG_IMAGE_COLUMNS  = 2'd1;
	localparam logic [1:0] REG_IMAGE_ROWS     = 2'd2;
	localparam logic [CFG_NW_W-1:0]   RST_ACTIVE_WINDOWS = 4'd8;
	localparam logic [CFG_SIDE_W-1:0] RST_IMAGE_SIDE     = 11'd1024;

	// Item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Steps of the squared-magnitude sequence (low and high halves of each part)
	localparam int PW_STEP_W = 3;
	localparam logic [PW_STEP_W-1:0] PW_RE_LL = 3'd0;
	localparam logic [PW_STEP_W-1:0] PW_RE_LH = 3'd1;
	localparam logic [PW_STEP_W-1:0] PW_RE_HH = 3'd2;
	localparam logic [PW_STEP_W-1:0] PW_IM_LL = 3'd3;
	localparam logic [PW_STEP_W-1:0] PW_IM_LH = 3'd4;
	localparam logic [PW_STEP_W-1:0] PW_IM_HH = 3'd5;
	localparam logic [PW_STEP_W-1:0] PW_LAST  = PW_IM_HH;

	// Controller to datapath commands
	typedef struct packed {
		logic                 tbl_wr;
		logic                 smp_ld;
		logic                 mac_rd;
		logic [WIN_W-1:0]     win;
		logic                 ch_inc;
		logic                 pw_ld;
		logic                 pw_mul;
		logic [PW_STEP_W-1:0] pw_step;
		logic                 pw_cmp;
		logic                 rot;
		logic                 emit;
	} mpwb_cmd_t;

	// Number of windows compared: zero counts as one, excess saturates
	function automatic logic [NW_W-1:0] clamp_nw(input logic [CFG_NW_W-1:0] v);
		if (v == '0)
			return NW_W'(1);
		else if (int'(v) > NUM_WINDOWS)
			return NW_W'(NUM_WINDOWS);
		else
			return NW_W'(v);
	endfunction

	// Last counter position of an image side after clamping
	function automatic logic [SIDE_W-1:0] side_last(input logic [CFG_SIDE_W-1:0] v);
		if (v == '0)
			return '0;
		else if (int'(v) > MAX_IMAGE_SIDE)
			return SIDE_W'(MAX_IMAGE_SIDE - 1);
		else
			return SIDE_W'(v - 1'b1);
	endfunction

endpackage

@@ src/mpwb_ctrl.sv @@
module mpwb_ctrl
	import mpwb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_kind,
	input  logic            in_last,
	input  logic [NW_W-1:0] nw,
	input  logic            out_free,
	output logic            in_ready,
	output mpwb_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_PSEL,
		S_PMUL,
		S_PDRAIN,
		S_PCMP,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [WIN_W-1:0]     win_q;
	logic [PW_STEP_W-1:0] step_q;
	logic                 last_q;
	logic                 drain_q;
	logic                 win_end;
	logic                 win_active;

	assign win_end    = (win_q == WIN_W'(NUM_WINDOWS - 1));
	assign win_active = (NW_W'(win_q) < nw);
	assign in_ready   = (state_q == S_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd         = '0;
		cmd.win     = win_q;
		cmd.pw_step = step_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.tbl_wr = in_valid && (in_kind == KIND_LOAD);
				cmd.smp_ld = in_valid && (in_kind == KIND_SAMPLE);
			end
			S_MAC: begin
				cmd.mac_rd = 1'b1;
				cmd.ch_inc = win_end && !last_q;
			end
			S_DRAIN: begin
			end
			S_PSEL: begin
				cmd.pw_ld = win_active;
				cmd.rot   = !win_active;
			end
			S_PMUL: begin
				cmd.pw_mul = 1'b1;
			end
			S_PDRAIN: begin
			end
			S_PCMP: begin
				cmd.pw_cmp = 1'b1;
				cmd.rot    = 1'b1;
			end
			S_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
			end
		endcase
	end

	// Sequence a sample: window reads; after the last channel, drain, compare, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q   <= '0;
			step_q  <= '0;
			last_q  <= 1'b0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && (in_kind == KIND_SAMPLE)) begin
						last_q  <= in_last;
						win_q   <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					win_q <= win_q + 1'b1;
					if (win_end) begin
						drain_q <= 1'b0;
						state_q <= last_q ? S_DRAIN : S_IDLE;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						win_q   <= '0;
						state_q <= S_PSEL;
					end
				end
				S_PSEL: begin
					if (win_active) begin
						step_q  <= '0;
						state_q <= S_PMUL;
					end else begin
						win_q <= win_q + 1'b1;
						if (win_end)
							state_q <= S_EMIT;
					end
				end
				S_PMUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == PW_LAST)
						state_q <= S_PDRAIN;
				end
				S_PDRAIN: begin
					state_q <= S_PCMP;
				end
				S_PCMP: begin
					win_q   <= win_q + 1'b1;
					state_q <= win_end ? S_EMIT : S_PSEL;
				end
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/mpwb_datapath.sv @@
module mpwb_datapath
	import mpwb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpwb_cmd_t             cmd,
	input  logic [IN_WIN_W-1:0]   in_window,
	input  logic [IN_CH_W-1:0]    in_channel,
	input  logic [SMP_W-1:0]      in_real,
	input  logic [SMP_W-1:0]      in_imag,
	input  logic [SIDE_W-1:0]     cols_last,
	input  logic [SIDE_W-1:0]     rows_last,
	input  logic                  out_ready,
	output logic                  out_free,
	output logic                  out_valid,
	output logic [ACC_W-1:0]      out_real,
	output logic [ACC_W-1:0]      out_imag,
	output logic [OUT_WIN_W-1:0]  out_window,
	output logic                  out_frame_end
);

	typedef enum logic [1:0] {
		SH_NONE,
		SH_MID,
		SH_HIGH
	} shift_t;

	// Coefficient table and MAC pipeline
	logic [COEF_W-1:0]        tbl_mem [TBL_DEPTH];
	logic [TBL_AW-1:0]        wr_addr;
	logic [TBL_AW-1:0]        rd_addr;
	logic                     wr_ok;
	logic [CH_W-1:0]          ch_q;
	logic signed [SMP_W-1:0]  smp_re_q;
	logic signed [SMP_W-1:0]  smp_im_q;
	logic [COEF_W-1:0]        coef_s1;
	logic                     mac_vld_s1;
	logic signed [SMP_W-1:0]  coef_re;
	logic signed [SMP_W-1:0]  coef_im;
	logic signed [COEF_W-1:0] p_rr;
	logic signed [COEF_W-1:0] p_ii;
	logic signed [COEF_W-1:0] p_ri;
	logic signed [COEF_W-1:0] p_ir;
	logic [PROD_W-1:0]        pr_s2;
	logic [PROD_W-1:0]        pi_s2;
	logic                     mac_vld_s2;

	// Accumulator ring, window at the head in slot 0
	logic [ACC_W-1:0]         acc_re_q [NUM_WINDOWS];
	logic [ACC_W-1:0]         acc_im_q [NUM_WINDOWS];

	// Squared magnitude unit
	logic [ACC_W-1:0]         mag_re_q;
	logic [ACC_W-1:0]         mag_im_q;
	logic [HALF_W-1:0]        op_a;
	logic [HALF_W-1:0]        op_b;
	shift_t                   op_sh;
	logic [ACC_W-1:0]         pw_prod_s1;
	shift_t                   pw_sh_s1;
	logic                     pw_vld_s1;
	logic [POW_W-1:0]         pow_q;
	logic [POW_W-1:0]         pow_term;

	// Best window so far
	logic [POW_W-1:0]         best_pow_q;
	logic [ACC_W-1:0]         best_re_q;
	logic [ACC_W-1:0]         best_im_q;
	logic [WIN_W-1:0]         best_win_q;

	// Frame position and output register
	logic [SIDE_W-1:0]        col_q;
	logic [SIDE_W-1:0]        row_q;
	logic                     col_wrap;
	logic                     row_wrap;
	logic                     out_valid_q;
	logic [ACC_W-1:0]         out_re_q;
	logic [ACC_W-1:0]         out_im_q;
	logic [OUT_WIN_W-1:0]     out_win_q;
	logic                     out_last_q;

	// Address the table by window and channel
	assign wr_ok   = (int'(in_window) < NUM_WINDOWS) && (int'(in_channel) < NUM_CHANNELS);
	assign wr_addr = TBL_AW'(int'(in_window) * NUM_CHANNELS + int'(in_channel));
	assign rd_addr = TBL_AW'(int'(cmd.win) * NUM_CHANNELS + int'(ch_q));

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && wr_ok)
			tbl_mem[wr_addr] <= {in_real, in_imag};
		if (cmd.mac_rd)
			coef_s1 <= tbl_mem[rd_addr];
	end

	// Hold the sample for all window passes
	always_ff @(posedge clk) begin
		if (cmd.smp_ld) begin
			smp_re_q <= in_real;
			smp_im_q <= in_imag;
		end
	end

	// Track the channel of the current sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ch_q <= '0;
		else if (cmd.emit)
			ch_q <= '0;
		else if (cmd.ch_inc)
			ch_q <= (int'(ch_q) == NUM_CHANNELS - 1) ? '0 : ch_q + 1'b1;
	end

	// Complex multiply of sample and coefficient
	assign coef_re = coef_s1[COEF_W-1:SMP_W];
	assign coef_im = coef_s1[SMP_W-1:0];
	assign p_rr    = smp_re_q * coef_re;
	assign p_ii    = smp_im_q * coef_im;
	assign p_ri    = smp_re_q * coef_im;
	assign p_ir    = smp_im_q * coef_re;

	always_ff @(posedge clk) begin
		pr_s2 <= {p_rr[COEF_W-1], p_rr} - {p_ii[COEF_W-1], p_ii};
		pi_s2 <= {p_ri[COEF_W-1], p_ri} + {p_ir[COEF_W-1], p_ir};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_vld_s1 <= 1'b0;
			mac_vld_s2 <= 1'b0;
		end else begin
			mac_vld_s1 <= cmd.mac_rd;
			mac_vld_s2 <= mac_vld_s1;
		end
	end

	// Rotate the ring: add a product, pass the head through, or clear on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				acc_re_q[i] <= '0;
				acc_im_q[i] <= '0;
			end
		end else if (cmd.emit) begin
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				acc_re_q[i] <= '0;
				acc_im_q[i] <= '0;
			end
		end else if (mac_vld_s2 || cmd.rot) begin
			for (int i = 0; i < NUM_WINDOWS - 1; i++) begin
				acc_re_q[i] <= acc_re_q[i+1];
				acc_im_q[i] <= acc_im_q[i+1];
			end
			if (mac_vld_s2) begin
				acc_re_q[NUM_WINDOWS-1] <= acc_re_q[0] +
					{{(ACC_W-PROD_W){pr_s2[PROD_W-1]}}, pr_s2};
				acc_im_q[NUM_WINDOWS-1] <= acc_im_q[0] +
					{{(ACC_W-PROD_W){pi_s2[PROD_W-1]}}, pi_s2};
			end else begin
				acc_re_q[NUM_WINDOWS-1] <= acc_re_q[0];
				acc_im_q[NUM_WINDOWS-1] <= acc_im_q[0];
			end
		end
	end

	// Take magnitudes of the head window
	always_ff @(posedge clk) begin
		if (cmd.pw_ld) begin
			mag_re_q <= acc_re_q[0][ACC_W-1] ? (~acc_re_q[0] + 1'b1) : acc_re_q[0];
			mag_im_q <= acc_im_q[0][ACC_W-1] ? (~acc_im_q[0] + 1'b1) : acc_im_q[0];
		end
	end

	// Pick the half-word operands of this step
	always_comb begin
		op_a  = mag_re_q[HALF_W-1:0];
		op_b  = mag_re_q[HALF_W-1:0];
		op_sh = SH_NONE;
		case (cmd.pw_step)
			PW_RE_LL: begin
				op_a  = mag_re_q[HALF_W-1:0];
				op_b  = mag_re_q[HALF_W-1:0];
				op_sh = SH_NONE;
			end
			PW_RE_LH: begin
				op_a  = mag_re_q[HALF_W-1:0];
				op_b  = mag_re_q[ACC_W-1:HALF_W];
				op_sh = SH_MID;
			end
			PW_RE_HH: begin
				op_a  = mag_re_q[ACC_W-1:HALF_W];
				op_b  = mag_re_q[ACC_W-1:HALF_W];
				op_sh = SH_HIGH;
			end
			PW_IM_LL: begin
				op_a  = mag_im_q[HALF_W-1:0];
				op_b  = mag_im_q[HALF_W-1:0];
				op_sh = SH_NONE;
			end
			PW_IM_LH: begin
				op_a  = mag_im_q[HALF_W-1:0];
				op_b  = mag_im_q[ACC_W-1:HALF_W];
				op_sh = SH_MID;
			end
			PW_IM_HH: begin
				op_a  = mag_im_q[ACC_W-1:HALF_W];
				op_b  = mag_im_q[ACC_W-1:HALF_W];
				op_sh = SH_HIGH;
			end
			default: begin
				op_sh = SH_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pw_prod_s1 <= op_a * op_b;
		pw_sh_s1   <= op_sh;
	end

	// Cross terms appear twice, hence one extra bit of shift
	always_comb begin
		case (pw_sh_s1)
			SH_MID:  pow_term = POW_W'(pw_prod_s1) << (HALF_W + 1);
			SH_HIGH: pow_term = POW_W'(pw_prod_s1) << ACC_W;
			default: pow_term = POW_W'(pw_prod_s1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pw_vld_s1 <= 1'b0;
		else
			pw_vld_s1 <= cmd.pw_mul;
	end

	always_ff @(posedge clk) begin
		if (cmd.pw_ld)
			pow_q <= '0;
		else if (pw_vld_s1)
			pow_q <= pow_q + pow_term;
	end

	// Keep the first window and any strictly smaller one
	always_ff @(posedge clk) begin
		if (cmd.pw_cmp && ((cmd.win == '0) || (pow_q < best_pow_q))) begin
			best_pow_q <= pow_q;
			best_re_q  <= acc_re_q[0];
			best_im_q  <= acc_im_q[0];
			best_win_q <= cmd.win;
		end
	end

	// Advance the pixel position on each result
	assign col_wrap = (col_q >= cols_last);
	assign row_wrap = (row_q >= rows_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.emit) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Output register: load on emit, drop once taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_re_q   <= best_re_q;
			out_im_q   <= best_im_q;
			out_win_q  <= OUT_WIN_W'(best_win_q);
			out_last_q <= col_wrap && row_wrap;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_real      = out_re_q;
	assign out_imag      = out_im_q;
	assign out_window    = out_win_q;
	assign out_frame_end = out_last_q;

endmodule

@@ src/min_power_window_beamformer.sv @@
// Channel   Dir  Handshake          Contents
// s_axis    in   tvalid/tready      tuser kind, tdata load or sample fields, tlast last channel
// m_axis    out  tvalid/tready      tdata least-power sum, tuser window, tlast frame end
// apb       in   psel/penable       three registers at byte addresses 0, 4, 8
//
// A load writes the coefficient table as it is accepted. A sample is accepted, then one
// coefficient is read per window through the single shared complex multiply-accumulate.
// A last-channel sample then drains, takes each compared window's squared magnitude over
// six half-word products on one multiplier, skips the other windows and then emits.
// Reset clears accumulators and counters and presets the registers; the table is not cleared.
// A stalled result waits in the output register while the next pixel is processed.
module min_power_window_beamformer
	import mpwb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// slave stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // window_index[2:0], channel_index[7:3],
	                                    // value_real[23:8], value_imag[39:24]
	input  logic              s_tuser,  // kind[0]
	input  logic              s_tlast,
	// master stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [79:0]       m_tdata,  // result_real[39:0], result_imag[79:40]
	output logic [2:0]        m_tuser,  // chosen_window[2:0]
	output logic              m_tlast,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [CFG_NW_W-1:0]   cfg_nw_q;
	logic [CFG_SIDE_W-1:0] cfg_cols_q;
	logic [CFG_SIDE_W-1:0] cfg_rows_q;
	logic                  cfg_wr;
	logic [1:0]            cfg_idx;
	mpwb_cmd_t             cmd;
	logic                  out_free;

	// Register file write and read
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_nw_q   <= RST_ACTIVE_WINDOWS;
			cfg_cols_q <= RST_IMAGE_SIDE;
			cfg_rows_q <= RST_IMAGE_SIDE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ACTIVE_WINDOWS: cfg_nw_q   <= pwdata[CFG_NW_W-1:0];
				REG_IMAGE_COLUMNS:  cfg_cols_q <= pwdata[CFG_SIDE_W-1:0];
				REG_IMAGE_ROWS:     cfg_rows_q <= pwdata[CFG_SIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ACTIVE_WINDOWS: prdata = APB_DW'(cfg_nw_q);
			REG_IMAGE_COLUMNS:  prdata = APB_DW'(cfg_cols_q);
			REG_IMAGE_ROWS:     prdata = APB_DW'(cfg_rows_q);
			default:            prdata = '0;
		endcase
	end

	mpwb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_last  (s_tlast),
		.nw       (clamp_nw(cfg_nw_q)),
		.out_free (out_free),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	mpwb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_window     (s_tdata[2:0]),
		.in_channel    (s_tdata[7:3]),
		.in_real       (s_tdata[23:8]),
		.in_imag       (s_tdata[39:24]),
		.cols_last     (side_last(cfg_cols_q)),
		.rows_last     (side_last(cfg_rows_q)),
		.out_ready     (m_tready),
		.out_free      (out_free),
		.out_valid     (m_tvalid),
		.out_real      (m_tdata[39:0]),
		.out_imag      (m_tdata[79:40]),
		.out_window    (m_tuser),
		.out_frame_end (m_tlast)
	);

endmodule
